// ===== hdl/tfn_pkg.sv =====
// Shared types and constants for the triangle face unit normal pipeline.
// No dependencies; used by the front end, root, divider and top level.
package tfn_pkg;

    localparam int FRONT_STAGES = 8;
    localparam int SQRT_STAGES  = 32;
    localparam int NORM_TOP     = 24;
    localparam int SQ_W         = 2 * NORM_TOP;
    localparam int RAD_W        = 62;
    localparam int ROOT_W       = 31;

    typedef struct packed {
        logic [2:0][NORM_TOP-1:0] mag;
        logic [2:0]               neg;
        logic                     degen;
    } side_t;

endpackage

// ===== hdl/tfn_front.sv =====
// Front end: edges, cross product, magnitude normalization and sum of squares.
// Depends on tfn_pkg.
module tfn_front #(
    parameter int COORD_BITS = 24
) (
    input  logic                                aclk,
    input  logic [tfn_pkg::FRONT_STAGES-1:0]    en,
    input  logic [8:0][COORD_BITS-1:0]          p,
    output tfn_pkg::side_t                      side,
    output logic [tfn_pkg::RAD_W-1:0]           rad
);
    import tfn_pkg::*;

    localparam int DROP = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
    localparam int EW   = COORD_BITS + 1 - DROP;
    localparam int PW   = 2 * EW;
    localparam int BLW  = $clog2(PW + 1);

    function automatic logic signed [EW-1:0] edge_of(input logic [COORD_BITS-1:0] u,
                                                     input logic [COORD_BITS-1:0] v);
        logic signed [COORD_BITS:0] d;
        logic [COORD_BITS:0]        dm;
        logic [COORD_BITS:0]        ds;
        d  = $signed({u[COORD_BITS-1], u}) - $signed({v[COORD_BITS-1], v});
        dm = d[COORD_BITS] ? -d : d;
        ds = dm >> DROP;
        return d[COORD_BITS] ? $signed(-ds[EW-1:0]) : $signed(ds[EW-1:0]);
    endfunction

    logic signed [EW-1:0]   ea_reg [3];
    logic signed [EW-1:0]   eb_reg [3];
    logic signed [PW-1:0]   pr_reg [6];
    logic signed [PW:0]     cr_next [3];
    logic [PW-1:0]          mg2_reg [3];
    logic [2:0]             neg2_reg;
    logic [PW-1:0]          mg3_reg [3];
    logic [2:0]             neg3_reg;
    logic [PW-1:0]          or3_reg;
    logic                   dg3_reg;
    logic [PW-1:0]          mg4_reg [3];
    logic [2:0]             neg4_reg;
    logic                   dg4_reg;
    logic [BLW-1:0]         bl_next;
    logic [BLW-1:0]         bl4_reg;
    logic [PW-1:0]          sh_next [3];
    side_t                  sd5_reg;
    side_t                  sd6_reg;
    logic [SQ_W-1:0]        sq6_reg [3];
    side_t                  sd7_reg;
    logic [RAD_W-1:0]       rad7_reg;
    logic [SQ_W+1:0]        sum_next;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                ea_reg[i] <= edge_of(p[i], p[3+i]);
                eb_reg[i] <= edge_of(p[i], p[6+i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            pr_reg[0] <= ea_reg[1] * eb_reg[2];
            pr_reg[1] <= ea_reg[2] * eb_reg[1];
            pr_reg[2] <= ea_reg[2] * eb_reg[0];
            pr_reg[3] <= ea_reg[0] * eb_reg[2];
            pr_reg[4] <= ea_reg[0] * eb_reg[1];
            pr_reg[5] <= ea_reg[1] * eb_reg[0];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cr_next[i] = pr_reg[2*i] - pr_reg[2*i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                mg2_reg[i]  <= PW'(cr_next[i][PW] ? -cr_next[i] : cr_next[i]);
                neg2_reg[i] <= cr_next[i][PW];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            mg3_reg  <= mg2_reg;
            neg3_reg <= neg2_reg;
            or3_reg  <= mg2_reg[0] | mg2_reg[1] | mg2_reg[2];
            dg3_reg  <= (mg2_reg[0] | mg2_reg[1] | mg2_reg[2]) == '0;
        end
    end

    always_comb begin
        bl_next = '0;
        for (int i = 0; i < PW; i++) begin
            if (or3_reg[i]) begin
                bl_next = BLW'(i + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            mg4_reg  <= mg3_reg;
            neg4_reg <= neg3_reg;
            dg4_reg  <= dg3_reg;
            bl4_reg  <= bl_next;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (int'(bl4_reg) > NORM_TOP) begin
                sh_next[i] = mg4_reg[i] >> (int'(bl4_reg) - NORM_TOP);
            end else begin
                sh_next[i] = mg4_reg[i] << (NORM_TOP - int'(bl4_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            for (int i = 0; i < 3; i++) begin
                sd5_reg.mag[i] <= sh_next[i][NORM_TOP-1:0];
            end
            sd5_reg.neg   <= neg4_reg;
            sd5_reg.degen <= dg4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            sd6_reg <= sd5_reg;
            for (int i = 0; i < 3; i++) begin
                sq6_reg[i] <= sd5_reg.mag[i] * sd5_reg.mag[i];
            end
        end
    end

    assign sum_next = (SQ_W+2)'(sq6_reg[0]) + (SQ_W+2)'(sq6_reg[1])
                    + (SQ_W+2)'(sq6_reg[2]);

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            sd7_reg  <= sd6_reg;
            rad7_reg <= {sum_next, 12'b0};
        end
    end

    assign side = sd7_reg;
    assign rad  = rad7_reg;

endmodule

// ===== hdl/tfn_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, from one radicand bit pair.
// Depends on tfn_pkg.
module tfn_sqrt (
    input  logic                                aclk,
    input  logic [tfn_pkg::SQRT_STAGES-1:0]     en,
    input  logic [tfn_pkg::RAD_W-1:0]           rad,
    input  tfn_pkg::side_t                      side_in,
    output logic [tfn_pkg::ROOT_W-1:0]          root,
    output tfn_pkg::side_t                      side_out
);
    import tfn_pkg::*;

    localparam int XW = RAD_W + 1;

    logic [XW-1:0] rem_reg [SQRT_STAGES];
    logic [XW-1:0] res_reg [SQRT_STAGES];
    side_t         sd_reg  [SQRT_STAGES];
    logic [XW-1:0] rem_w   [SQRT_STAGES];
    logic [XW-1:0] res_w   [SQRT_STAGES];
    side_t         sd_w    [SQRT_STAGES];

    assign rem_w[0] = {1'b0, rad};
    assign res_w[0] = '0;
    assign sd_w[0]  = side_in;

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
        localparam logic [XW-1:0] BIT_V = {{(XW-1){1'b0}}, 1'b1} << (RAD_W - 2*j);
        logic [XW-1:0] trial;

        if (j > 0) begin : g_link
            assign rem_w[j] = rem_reg[j-1];
            assign res_w[j] = res_reg[j-1];
            assign sd_w[j]  = sd_reg[j-1];
        end

        assign trial = res_w[j] + BIT_V;

        always_ff @(posedge aclk) begin
            if (en[j]) begin
                sd_reg[j] <= sd_w[j];
                if (rem_w[j] >= trial) begin
                    rem_reg[j] <= rem_w[j] - trial;
                    res_reg[j] <= (res_w[j] >> 1) + BIT_V;
                end else begin
                    rem_reg[j] <= rem_w[j];
                    res_reg[j] <= res_w[j] >> 1;
                end
            end
        end
    end

    assign root     = res_reg[SQRT_STAGES-1][ROOT_W-1:0];
    assign side_out = sd_reg[SQRT_STAGES-1];

endmodule

// ===== hdl/tfn_div.sv =====
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Depends on tfn_pkg.
module tfn_div #(
    parameter int NORMAL_BITS = 16
) (
    input  logic                                aclk,
    input  logic [NORMAL_BITS-2:0]              en,
    input  logic [tfn_pkg::ROOT_W-1:0]          root,
    input  tfn_pkg::side_t                      side_in,
    output logic [2:0][NORMAL_BITS-2:0]         quo,
    output tfn_pkg::side_t                      side_out
);
    import tfn_pkg::*;

    localparam int QB = NORMAL_BITS - 1;
    localparam int NW = NORMAL_BITS + 30;

    logic [2:0][NW-1:0]  num_reg  [QB];
    logic [2:0][QB-1:0]  q_reg    [QB];
    logic [ROOT_W-1:0]   root_reg [QB];
    side_t               sd_reg   [QB];
    logic [2:0][NW-1:0]  num_w    [QB];
    logic [2:0][QB-1:0]  q_w      [QB];
    logic [ROOT_W-1:0]   root_w   [QB];
    side_t               sd_w     [QB];

    for (genvar i = 0; i < 3; i++) begin : g_load
        assign num_w[0][i] = NW'(side_in.mag[i]) << (NORMAL_BITS + 4);
    end
    assign q_w[0]    = '0;
    assign root_w[0] = root;
    assign sd_w[0]   = side_in;

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int SH = QB - 1 - k;
        logic [NW-1:0] dv;

        if (k > 0) begin : g_link
            assign num_w[k]  = num_reg[k-1];
            assign q_w[k]    = q_reg[k-1];
            assign root_w[k] = root_reg[k-1];
            assign sd_w[k]   = sd_reg[k-1];
        end

        assign dv = NW'(root_w[k]) << SH;

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                root_reg[k] <= root_w[k];
                sd_reg[k]   <= sd_w[k];
                for (int i = 0; i < 3; i++) begin
                    if (num_w[k][i] >= dv) begin
                        num_reg[k][i]   <= num_w[k][i] - dv;
                        q_reg[k][i]     <= q_w[k][i] | (QB'(1) << SH);
                    end else begin
                        num_reg[k][i]   <= num_w[k][i];
                        q_reg[k][i]     <= q_w[k][i];
                    end
                end
            end
        end
    end

    assign quo      = q_reg[QB-1];
    assign side_out = sd_reg[QB-1];

endmodule

// ===== hdl/triangle_face_unit_normal.sv =====
// Top level of the triangle face unit normal pipeline: stream ports, flow control, output.
// Depends on tfn_pkg, tfn_front, tfn_sqrt and tfn_div.
//
// Takes one face (three Q8.16 corners) per cycle unless a stall on the result side backs up
// the pipeline, and returns its unit normal in Q1.14, or a zero normal with the degenerate
// flag when the corners are collinear. Each face passes through the front end, the 32-stage
// square root, the one-bit-per-stage divider and an output register. Every stage holds its
// own valid bit, so bubbles close up when the result side stalls and a full pipeline keeps
// accepting as long as results are taken.
module triangle_face_unit_normal #(
    parameter int COORD_BITS  = 24,
    parameter int NORMAL_BITS = 16,
    localparam int S_W = ((9 * COORD_BITS + 7) / 8) * 8,
    localparam int M_W = ((3 * NORMAL_BITS + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [S_W-1:0] s_tdata,   // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [M_W-1:0] m_tdata,   // normal_x, normal_y, normal_z
    output logic           m_tuser    // degenerate
);
    import tfn_pkg::*;

    localparam int QB = NORMAL_BITS - 1;
    localparam int NT = FRONT_STAGES + SQRT_STAGES + QB + 1;

    logic [NT-1:0]                  v_reg;
    logic [NT-1:0]                  en;
    logic [8:0][COORD_BITS-1:0]     p;
    side_t                          fr_side;
    logic [RAD_W-1:0]               fr_rad;
    side_t                          sq_side;
    logic [ROOT_W-1:0]              sq_root;
    side_t                          dv_side;
    logic [2:0][QB-1:0]             dv_quo;
    logic [2:0][NORMAL_BITS-1:0]    out_next;
    logic [3*NORMAL_BITS-1:0]       out_data_reg;
    logic                           out_degen_reg;

    always_comb begin
        en[NT-1] = !v_reg[NT-1] || m_tready;
        for (int k = NT - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NT; k++) begin
                if (en[k]) begin
                    v_reg[k] <= (k == 0) ? s_tvalid : v_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    for (genvar i = 0; i < 9; i++) begin : g_unpack
        assign p[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
    end

    tfn_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk (aclk),
        .en   (en[FRONT_STAGES-1:0]),
        .p    (p),
        .side (fr_side),
        .rad  (fr_rad)
    );

    tfn_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en[FRONT_STAGES+SQRT_STAGES-1:FRONT_STAGES]),
        .rad      (fr_rad),
        .side_in  (fr_side),
        .root     (sq_root),
        .side_out (sq_side)
    );

    tfn_div #(.NORMAL_BITS(NORMAL_BITS)) u_div (
        .aclk     (aclk),
        .en       (en[NT-2:FRONT_STAGES+SQRT_STAGES]),
        .root     (sq_root),
        .side_in  (sq_side),
        .quo      (dv_quo),
        .side_out (dv_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dv_side.degen) begin
                out_next[i] = '0;
            end else if (dv_side.neg[i]) begin
                out_next[i] = -{1'b0, dv_quo[i]};
            end else begin
                out_next[i] = {1'b0, dv_quo[i]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NT-1]) begin
            out_data_reg  <= out_next;
            out_degen_reg <= dv_side.degen;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NT-1];
    assign m_tdata  = M_W'(out_data_reg);
    assign m_tuser  = out_degen_reg;

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> out_data_reg == '0)
        else $error("degenerate face with nonzero normal");

    a_normal_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> out_data_reg != '0)
        else $error("zero normal without degenerate flag");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> &v_reg)
        else $error("input stalled with a bubble in the pipeline");

endmodule

// ===== dv/triangle_face_unit_normal_chk.sv =====
// Checker for triangle_face_unit_normal: watches both stream channels, predicts each normal.
// Depends on nothing but the block's port widths; hands a failure count to the testbench top.
`timescale 1ns / 1ps
module triangle_face_unit_normal_chk #(
    parameter int S_W = 216,
    parameter int M_W = 48
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [S_W-1:0] s_tdata,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [M_W-1:0] m_tdata,
    input  logic           m_tuser,
    output int             fail_count,
    output int             pending
);
    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degen;
    } normal_t;

    normal_t expected_normals[$];

    assign pending = expected_normals.size();

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic normal_t face_normal(logic [S_W-1:0] d);
        longint      pt[9];
        longint      e1[3];
        longint      e2[3];
        longint      cr[3];
        logic [63:0] mg[3];
        logic [63:0] big;
        logic [63:0] sq;
        logic [63:0] len;
        logic [63:0] q;
        logic [15:0] o[3];
        int          bl;
        normal_t     r;
        for (int i = 0; i < 9; i++) pt[i] = longint'($signed(d[i*24 +: 24]));
        for (int i = 0; i < 3; i++) begin
            e1[i] = pt[i] - pt[3+i];
            e2[i] = pt[i] - pt[6+i];
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
            r = '{16'd0, 16'd0, 16'd0, 1'b1};
            return r;
        end
        big = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = cr[i] < 0 ? 64'(-cr[i]) : 64'(cr[i]);
            if (mg[i] > big) big = mg[i];
        end
        bl = 0;
        while (big != 0) begin
            big = big >> 1;
            bl++;
        end
        for (int i = 0; i < 3; i++)
            mg[i] = bl > 24 ? mg[i] >> (bl - 24) : mg[i] << (24 - bl);
        sq = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
        len = int_sqrt(sq << 12);
        for (int i = 0; i < 3; i++) begin
            q = (mg[i] << 20) / len;
            if (q > 64'd32767) q = 64'd32767;
            o[i] = cr[i] < 0 ? 16'(-q) : 16'(q);
        end
        r = '{o[0], o[1], o[2], 1'b0};
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0h, want %0h", what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        normal_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) expected_normals.push_back(face_normal(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_normals.size() == 0) begin
                    report_mismatch("unexpected normal_x", m_tdata[15:0], 16'd0);
                end else begin
                    want = expected_normals.pop_front();
                    if (m_tdata[15:0] !== want.nx) report_mismatch("normal_x", m_tdata[15:0], want.nx);
                    if (m_tdata[31:16] !== want.ny) report_mismatch("normal_y", m_tdata[31:16], want.ny);
                    if (m_tdata[47:32] !== want.nz) report_mismatch("normal_z", m_tdata[47:32], want.nz);
                    if (m_tuser !== want.degen)
                        report_mismatch("degenerate", 16'(m_tuser), 16'(want.degen));
                end
            end
        end
    end
endmodule

// ===== dv/triangle_face_unit_normal_tb.sv =====
// Testbench top for triangle_face_unit_normal: drives faces, stalls the result side, gives the verdict.
// Depends on the block and triangle_face_unit_normal_chk.
`timescale 1ns / 1ps
module triangle_face_unit_normal_tb;
    localparam int S_W   = 216;
    localparam int M_W   = 48;
    localparam int LIMIT = 200000;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic           m_tuser;
    int             fail_count;
    int             pending;
    int             cycles = 0;
    bit             calm = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    triangle_face_unit_normal DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    triangle_face_unit_normal_chk #(.S_W(S_W), .M_W(M_W)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    always @(negedge aclk) m_tready <= calm || ($urandom_range(99) >= 34);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'($urandom_range(255)) - 24'd128;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_face(logic [S_W-1:0] d);
        while (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [S_W-1:0] pack9(logic [23:0] v[9]);
        logic [S_W-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[i*24 +: 24] = v[i];
        return d;
    endfunction

    initial begin
        logic [23:0]    v[9];
        logic [S_W-1:0] d;
        int             mode;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_face('0);
        for (int i = 0; i < 9; i++) v[i] = 24'h800000;
        send_face(pack9(v));
        for (int i = 0; i < 9; i++) v[i] = 24'h7fffff;
        send_face(pack9(v));
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 9; i++)
                v[i] = (i == 3 || i == 7 || i == 2) ^ k[0] ? 24'h7fffff : 24'h800000;
            if (k[1]) v[5] = 24'h7fffff;
            send_face(pack9(v));
        end
        v = '{24'd0, 24'd0, 24'd0, 24'h010000, 24'd0, 24'd0, 24'd0, 24'h010000, 24'd0};
        send_face(pack9(v));
        v = '{24'd0, 24'd0, 24'd0, 24'h010000, 24'h010000, 24'd0, 24'h020000, 24'h020000, 24'd0};
        send_face(pack9(v));
        v = '{24'd5, 24'd0, 24'd0, 24'd6, 24'd0, 24'd0, 24'd5, 24'd1, 24'd0};
        send_face(pack9(v));
        v = '{24'd5, 24'd0, 24'd0, 24'd5, 24'd0, 24'd1, 24'd6, 24'd0, 24'd0};
        send_face(pack9(v));
        for (int n = 0; n < 1000; n++) begin
            calm = (n >= 300 && n < 400);
            if (n == 500) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (pending != 0) @(negedge aclk);
            end
            mode = $urandom_range(9);
            for (int i = 0; i < 9; i++)
                v[i] = rand_coord(mode < 2 ? $urandom_range(3) : (mode < 4 ? 2 : 3));
            if (mode == 9) begin
                for (int i = 0; i < 3; i++) v[6+i] = v[3+i];
            end
            send_face(pack9(v));
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
